FILE: rtl/counting_semaphore_unit_core_defines.svh
// assertion macros shared by the semaphore unit
`ifndef COUNTING_SEMAPHORE_UNIT_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_UNIT_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define CSU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen out of reset
`define CSU_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CSU_ASSERT(label, clk, rst_n, prop, msg)
`define CSU_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/csu_pkg.sv
package csu_pkg;

	// fixed field widths
	localparam int MODE_W   = 2;
	localparam int SEM_ID_W = 3;
	localparam int PID_W    = 5;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 3;
	localparam int ERR_W    = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	typedef enum logic [MODE_W-1:0] {
		MODE_INIT   = 2'd0,
		MODE_WAIT   = 2'd1,
		MODE_POST   = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INITIALIZED = 3'd0,
		ST_GRANTED     = 3'd1,
		ST_BLOCKED     = 3'd2,
		ST_RAISED      = 3'd3,
		ST_RELEASED    = 3'd4,
		ST_ERROR       = 3'd5
	} status_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE   = 2'd0,
		ERR_NO_SEM = 2'd1,
		ERR_QFULL  = 2'd2
	} err_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture beat and read semaphore record
		logic commit;    // write record back, load result unless releasing
		logic rel_load;  // load released-waiter result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic release_op;  // post with a waiter queued
		logic out_free;    // result register can take a new beat
	} sts_t;

endpackage

FILE: rtl/csu_ctrl.sv
module csu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  csu_pkg::sts_t sts,
	output csu_pkg::cmd_t cmd
);
	import csu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_EXEC    = 3'b010,
		S_RELEASE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.commit   = 1'b0;
		cmd.rel_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (sts.release_op) begin
					cmd.commit = 1'b1;
					state_d    = S_RELEASE;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end else begin
					// hold while the result register is busy
					state_d    = S_EXEC;
				end
			end
			S_RELEASE: begin
				if (sts.out_free) begin
					cmd.rel_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

FILE: rtl/csu_datapath.sv
`include "counting_semaphore_unit_core_defines.svh"

module csu_datapath #(
	parameter int NUM_SEMS   = 8,
	parameter int WAIT_DEPTH = 16,
	parameter int NUM_PROCS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  csu_pkg::cmd_t                    cmd,
	output csu_pkg::sts_t                    sts,
	input  logic [csu_pkg::MODE_W-1:0]       mode,
	input  logic [csu_pkg::SEM_ID_W-1:0]     sem_id,
	input  logic [csu_pkg::PID_W-1:0]        caller_pid,
	input  logic [csu_pkg::COUNT_W-1:0]      init_count,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [csu_pkg::STATUS_W-1:0]     status,
	output logic [csu_pkg::ERR_W-1:0]        error_kind,
	output logic [csu_pkg::SEM_ID_W-1:0]     result_sem_id,
	output logic [csu_pkg::PID_W-1:0]        released_pid,
	output logic [csu_pkg::COUNT_W-1:0]      count_now
);
	import csu_pkg::*;

	localparam int SEM_W   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int NXT_W   = $clog2(NUM_SEMS + 1);
	localparam int HEAD_W  = $clog2(WAIT_DEPTH);
	localparam int FILL_W  = $clog2(WAIT_DEPTH + 1);
	localparam int SUM_W   = FILL_W + 1;
	localparam int WQ_N    = NUM_SEMS * WAIT_DEPTH;
	localparam int WADDR_W = $clog2(WQ_N);

	// sem id modulo the table size, one conditional subtract per bit
	function automatic logic [SEM_W-1:0] sem_reduce(input logic [SEM_ID_W-1:0] v);
		logic [31:0] r;
		r = 32'(v);
		for (int k = SEM_ID_W - 1; k >= 0; k--) begin
			if (r >= (32'(NUM_SEMS) << k)) begin
				r = r - (32'(NUM_SEMS) << k);
			end
		end
		return r[SEM_W-1:0];
	endfunction

	// pid modulo the process count
	function automatic logic [PID_W-1:0] pid_reduce(input logic [PID_W-1:0] v);
		logic [31:0] r;
		r = 32'(v);
		for (int k = PID_W - 1; k >= 0; k--) begin
			if (r >= (32'(NUM_PROCS) << k)) begin
				r = r - (32'(NUM_PROCS) << k);
			end
		end
		return r[PID_W-1:0];
	endfunction

	// per-semaphore record and wait queue storage
	logic [COUNT_W-1:0] count_mem  [NUM_SEMS];
	logic [HEAD_W-1:0]  head_mem   [NUM_SEMS];
	logic [FILL_W-1:0]  fill_mem   [NUM_SEMS];
	logic [PID_W-1:0]   waiter_mem [WQ_N];

	// captured beat
	mode_t              op_q;
	logic [SEM_W-1:0]   sid_q;
	logic [PID_W-1:0]   pid_q;
	logic [COUNT_W-1:0] icnt_q;
	logic               init_ok_q;
	logic [NXT_W-1:0]   next_free_q;

	// record read data
	logic [COUNT_W-1:0] cnt_rd_q;
	logic [HEAD_W-1:0]  head_rd_q;
	logic [FILL_W-1:0]  fill_rd_q;
	logic [PID_W-1:0]   waiter_rd_q;

	// result register
	logic               out_valid_q;
	status_t            status_q;
	err_t               err_q;
	logic [SEM_ID_W-1:0] id_q;
	logic [PID_W-1:0]   rel_pid_q;
	logic [COUNT_W-1:0] count_q;

	logic [SEM_W-1:0]   rd_addr;
	logic               init_ok;

	status_t            ex_status;
	err_t               ex_err;
	logic [SEM_ID_W-1:0] ex_id;
	logic [COUNT_W-1:0] ex_cnt;
	logic [COUNT_W-1:0] new_cnt;
	logic [HEAD_W-1:0]  new_head;
	logic [FILL_W-1:0]  new_fill;
	logic               ex_we;
	logic               blocked;
	logic               release_op;

	logic [SUM_W-1:0]   tail_sum;
	logic [HEAD_W-1:0]  tail_slot;
	logic [HEAD_W-1:0]  head_inc;
	logic [HEAD_W-1:0]  wq_slot;
	logic [WADDR_W-1:0] wq_addr;

	logic               rec_we;
	logic               wq_we;
	logic               wq_re;
	logic               out_load;

	// record address: next unused id for init, addressed id otherwise
	assign init_ok = (next_free_q < NXT_W'(NUM_SEMS));
	assign rd_addr = (mode_t'(mode) == MODE_INIT) ? next_free_q[SEM_W-1:0] : sem_reduce(sem_id);

	// beat capture and record read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= mode_t'(mode);
			sid_q     <= rd_addr;
			pid_q     <= pid_reduce(caller_pid);
			icnt_q    <= init_count;
			init_ok_q <= init_ok;
			cnt_rd_q  <= count_mem[rd_addr];
			head_rd_q <= head_mem[rd_addr];
			fill_rd_q <= fill_mem[rd_addr];
		end
	end

	// queue slot arithmetic
	assign tail_sum  = SUM_W'(head_rd_q) + SUM_W'(fill_rd_q);
	assign tail_slot = (tail_sum >= SUM_W'(WAIT_DEPTH)) ?
		HEAD_W'(tail_sum - SUM_W'(WAIT_DEPTH)) : HEAD_W'(tail_sum);
	assign head_inc  = (head_rd_q == HEAD_W'(WAIT_DEPTH - 1)) ? '0 : head_rd_q + 1'b1;

	// operation decode on the read record
	always_comb begin
		ex_status  = ST_ERROR;
		ex_err     = ERR_NONE;
		ex_id      = SEM_ID_W'(sid_q);
		ex_cnt     = '0;
		new_cnt    = cnt_rd_q;
		new_head   = head_rd_q;
		new_fill   = fill_rd_q;
		ex_we      = 1'b0;
		blocked    = 1'b0;
		release_op = 1'b0;
		unique case (op_q)
			MODE_INIT: begin
				if (init_ok_q) begin
					ex_status = ST_INITIALIZED;
					ex_cnt    = icnt_q;
					new_cnt   = icnt_q;
					new_head  = '0;
					new_fill  = '0;
					ex_we     = 1'b1;
				end else begin
					ex_err = ERR_NO_SEM;
					ex_id  = '0;
				end
			end
			MODE_WAIT: begin
				priority if (cnt_rd_q != '0) begin
					ex_status = ST_GRANTED;
					new_cnt   = cnt_rd_q - 1'b1;
					ex_cnt    = cnt_rd_q - 1'b1;
					ex_we     = 1'b1;
				end else if (fill_rd_q >= FILL_W'(WAIT_DEPTH)) begin
					ex_err = ERR_QFULL;
					ex_cnt = cnt_rd_q;
				end else begin
					ex_status = ST_BLOCKED;
					ex_cnt    = cnt_rd_q;
					new_fill  = fill_rd_q + 1'b1;
					ex_we     = 1'b1;
					blocked   = 1'b1;
				end
			end
			MODE_POST: begin
				if (fill_rd_q == '0) begin
					ex_status = ST_RAISED;
					new_cnt   = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + 1'b1;
					ex_cnt    = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + 1'b1;
					ex_we     = 1'b1;
				end else begin
					ex_status  = ST_RELEASED;
					ex_cnt     = cnt_rd_q;
					new_head   = head_inc;
					new_fill   = fill_rd_q - 1'b1;
					ex_we      = 1'b1;
					release_op = 1'b1;
				end
			end
			MODE_UNUSED: begin
				ex_status = ST_ERROR;
			end
		endcase
	end

	assign rec_we   = cmd.commit && ex_we;
	assign wq_we    = cmd.commit && blocked;
	assign wq_re    = cmd.commit && release_op;
	assign out_load = (cmd.commit && !release_op) || cmd.rel_load;

	// wait queue address: semaphore base plus slot
	assign wq_slot = blocked ? tail_slot : head_rd_q;
	assign wq_addr = (WADDR_W'(sid_q) * WADDR_W'(WAIT_DEPTH)) + WADDR_W'(wq_slot);

	// record write-back
	always_ff @(posedge clk) begin
		if (rec_we) begin
			count_mem[sid_q] <= new_cnt;
			head_mem[sid_q]  <= new_head;
			fill_mem[sid_q]  <= new_fill;
		end
	end

	// wait queue write and read
	always_ff @(posedge clk) begin
		if (wq_we) begin
			waiter_mem[wq_addr] <= pid_q;
		end
		if (wq_re) begin
			waiter_rd_q <= waiter_mem[wq_addr];
		end
	end

	// allocation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
		end else if (cmd.commit && (op_q == MODE_INIT) && init_ok_q) begin
			next_free_q <= next_free_q + 1'b1;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.rel_load) begin
			status_q  <= ST_RELEASED;
			err_q     <= ERR_NONE;
			id_q      <= SEM_ID_W'(sid_q);
			rel_pid_q <= waiter_rd_q;
			count_q   <= cnt_rd_q;
		end else if (out_load) begin
			status_q  <= ex_status;
			err_q     <= ex_err;
			id_q      <= ex_id;
			rel_pid_q <= '0;
			count_q   <= ex_cnt;
		end
	end

	assign sts.release_op = release_op;
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign error_kind    = err_q;
	assign result_sem_id = id_q;
	assign released_pid  = rel_pid_q;
	assign count_now     = count_q;

	`CSU_NEVER(a_out_overwrite, clk, arst_n, out_load && out_valid_q && out_stall, "result overwritten while held")
	`CSU_NEVER(a_fill_range, clk, arst_n, rec_we && (new_fill > FILL_W'(WAIT_DEPTH)), "wait queue fill beyond depth")
	`CSU_NEVER(a_alloc_range, clk, arst_n, next_free_q > NXT_W'(NUM_SEMS), "allocation counter beyond table")
	`CSU_ASSERT(a_rel_pid, clk, arst_n, out_valid_q && (status_q != ST_RELEASED) |-> (rel_pid_q == '0), "released pid set without release")

endmodule

FILE: rtl/counting_semaphore_unit_core.sv
// channel  direction  handshake            fields
// in       input      in_valid / in_stall  mode, sem_id, caller_pid, init_count
// out      output     out_valid / out_stall status, error_kind, result_sem_id,
//                                          released_pid, count_now
//
// init, wait and post pass through S_IDLE and S_EXEC; a post that releases a waiter also passes
// through S_RELEASE, which loads the result from the wait queue entry read at the record update.
// the semaphore record memory is read on the accept edge and written back on the commit in S_EXEC.
// arst_n clears the controller, the allocation counter and the result valid.
// a stalled result holds; the next beat is taken while it waits and finishes
// once the result register frees up.
module counting_semaphore_unit_core #(
	parameter int NUM_SEMS   = 8,
	parameter int WAIT_DEPTH = 16,
	parameter int NUM_PROCS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [csu_pkg::MODE_W-1:0]   mode,
	input  logic [csu_pkg::SEM_ID_W-1:0] sem_id,
	input  logic [csu_pkg::PID_W-1:0]    caller_pid,
	input  logic [csu_pkg::COUNT_W-1:0]  init_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [csu_pkg::STATUS_W-1:0] status,
	output logic [csu_pkg::ERR_W-1:0]    error_kind,
	output logic [csu_pkg::SEM_ID_W-1:0] result_sem_id,
	output logic [csu_pkg::PID_W-1:0]    released_pid,
	output logic [csu_pkg::COUNT_W-1:0]  count_now
);
	import csu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	csu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// semaphore table, wait queues and result register
	csu_datapath #(
		.NUM_SEMS   (NUM_SEMS),
		.WAIT_DEPTH (WAIT_DEPTH),
		.NUM_PROCS  (NUM_PROCS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.sem_id        (sem_id),
		.caller_pid    (caller_pid),
		.init_count    (init_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.error_kind    (error_kind),
		.result_sem_id (result_sem_id),
		.released_pid  (released_pid),
		.count_now     (count_now)
	);

endmodule
